[design/cbm_pkg.sv]
// Shared types and constants for the cartridge bank mapper.
// Used by the bank register file, the translator and the top level.
// No dependencies.
`default_nettype none

package cbm_pkg;

    // Bus operation carried by each input word.
    typedef enum logic [1:0] {
        FUNC_CPU_WR = 2'd0,
        FUNC_CPU_RD = 2'd1,
        FUNC_PPU_RD = 2'd2
    } t_func;

    // Destination of a translated access.
    typedef enum logic [2:0] {
        TGT_NONE    = 3'd0,
        TGT_PRG_RAM = 3'd1,
        TGT_PRG_ROM = 3'd2,
        TGT_CHR_ROM = 3'd3,
        TGT_NT_RAM  = 3'd4
    } t_target;

    // Configuration register indexes.
    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_PRG_MASK = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_CHR_MASK = 2'd1;

    // Bank register offsets, decoded on address bits 11..0 in the 7000-7FFF window.
    localparam logic [11:0] OFS_CHR0  = 12'hEF0;
    localparam logic [11:0] OFS_CHR1  = 12'hEF1;
    localparam logic [11:0] OFS_CHR2  = 12'hEF2;
    localparam logic [11:0] OFS_CHR3  = 12'hEF3;
    localparam logic [11:0] OFS_CHR4  = 12'hEF4;
    localparam logic [11:0] OFS_CHR5  = 12'hEF5;
    localparam logic [11:0] OFS_PRG0A = 12'hEFA;
    localparam logic [11:0] OFS_PRG0B = 12'hEFB;
    localparam logic [11:0] OFS_PRG1A = 12'hEFC;
    localparam logic [11:0] OFS_PRG1B = 12'hEFD;
    localparam logic [11:0] OFS_PRG2A = 12'hEFE;
    localparam logic [11:0] OFS_PRG2B = 12'hEFF;

    // Bank value constants.
    localparam logic [7:0] CHR_LOW_MASK  = 8'h7F;
    localparam logic [7:0] CHR_2K_MASK   = 8'h7E;
    localparam logic [7:0] PRG_FIXED     = 8'hFF;
    localparam logic [7:0] PRG2_RESET    = 8'hFE;
    localparam logic [7:0] MASK_RESET    = 8'hFF;

    // One input word.
    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_req;

    // One result word.
    typedef struct packed {
        logic [2:0]  target;
        logic [20:0] mapped_addr;
    } t_rsp;

    // Bank state seen by the translator.
    typedef struct packed {
        logic [2:0][7:0] prg_banks;
        logic [5:0][7:0] chr_banks;
        logic [1:0]      mirror_pages;
        logic [7:0]      prg_bank_mask;
        logic [7:0]      chr_bank_mask;
    } t_bank_state;

endpackage

`default_nettype wire

[design/cbm_req_if.sv]
// Request channel: valid/ready handshake carrying one bus access word.
// Depends on nothing; field widths follow the mapper's input word.
`default_nettype none

interface cbm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] addr;
    logic [7:0]  data;

    modport source (output valid, output func, output addr, output data, input ready);
    modport sink   (input valid, input func, input addr, input data, output ready);
endinterface

`default_nettype wire

[design/cbm_rsp_if.sv]
// Response channel: valid/ready handshake carrying one translated access word.
// Depends on nothing; field widths follow the mapper's result word.
`default_nettype none

interface cbm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [20:0] mapped_addr;

    modport source (output valid, output target, output mapped_addr, input ready);
    modport sink   (input valid, input target, input mapped_addr, output ready);
endinterface

`default_nettype wire

[design/cbm_regs.sv]
// Bank register file: program, character and mirroring registers plus the two size masks.
// Depends on cbm_pkg. Bus writes land when the word leaves the input register.
`default_nettype none

module cbm_regs
    import cbm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [7:0]           i_cfg_data,
    input  wire logic                 i_upd,
    input  wire t_req                 i_req,
    output t_bank_state               o_state
);

    logic [2:0][7:0] r_prg;
    logic [5:0][7:0] r_chr;
    logic [1:0]      r_mirror;
    logic [7:0]      r_prg_mask;
    logic [7:0]      r_chr_mask;
    logic            wr_hit;

    // A bus write to 7000-7FFF reaches the register decode.
    assign wr_hit = i_upd && (i_req.func == FUNC_CPU_WR) && (i_req.addr[15:12] == 4'h7);

    // Bank registers, loaded from the data byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg[0] <= 8'h00;
            r_prg[1] <= 8'h01;
            r_prg[2] <= PRG2_RESET;
            for (int i = 0; i < 6; i++) begin
                r_chr[i] <= 8'(i);
            end
            r_mirror <= 2'b00;
        end else if (wr_hit) begin
            case (i_req.addr[11:0])
                OFS_CHR0: begin
                    r_chr[0]    <= i_req.data & CHR_LOW_MASK;
                    r_mirror[0] <= i_req.data[7];
                end
                OFS_CHR1: begin
                    r_chr[1]    <= i_req.data & CHR_LOW_MASK;
                    r_mirror[1] <= i_req.data[7];
                end
                OFS_CHR2:             r_chr[2] <= i_req.data;
                OFS_CHR3:             r_chr[3] <= i_req.data;
                OFS_CHR4:             r_chr[4] <= i_req.data;
                OFS_CHR5:             r_chr[5] <= i_req.data;
                OFS_PRG0A, OFS_PRG0B: r_prg[0] <= i_req.data;
                OFS_PRG1A, OFS_PRG1B: r_prg[1] <= i_req.data;
                OFS_PRG2A, OFS_PRG2B: r_prg[2] <= i_req.data;
                default: ;
            endcase
        end
    end

    // Size masks from the configuration port; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_mask <= MASK_RESET;
            r_chr_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRG_MASK: r_prg_mask <= i_cfg_data;
                CFG_CHR_MASK: r_chr_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_state.prg_banks     = r_prg;
    assign o_state.chr_banks     = r_chr;
    assign o_state.mirror_pages  = r_mirror;
    assign o_state.prg_bank_mask = r_prg_mask;
    assign o_state.chr_bank_mask = r_chr_mask;

endmodule

`default_nettype wire

[design/cbm_xlate.sv]
// Address translator: turns one bus access and the current bank state into a target and address.
// Depends on cbm_pkg. Purely combinational.
`default_nettype none

module cbm_xlate
    import cbm_pkg::*;
(
    input  wire t_req        i_req,
    input  wire t_bank_state i_state,
    output t_rsp             o_rsp
);

    logic [1:0] prg_win;
    logic [7:0] prg_bank;
    logic [2:0] chr_win;
    logic [2:0] chr_idx;
    logic [7:0] chr_bank;

    // Program window bank: E000 window is fixed to the last bank.
    assign prg_win = i_req.addr[14:13];
    always_comb begin
        case (prg_win)
            2'd0:    prg_bank = i_state.prg_banks[0];
            2'd1:    prg_bank = i_state.prg_banks[1];
            2'd2:    prg_bank = i_state.prg_banks[2];
            default: prg_bank = PRG_FIXED;
        endcase
    end

    // Character window bank: two 2K windows, then four 1K windows.
    assign chr_win = i_req.addr[12:10];
    assign chr_idx = chr_win - 3'd2;
    always_comb begin
        if (!chr_win[2]) begin
            chr_bank = (i_state.chr_banks[{2'b00, chr_win[1]}] & CHR_2K_MASK)
                     | {7'b0, chr_win[0]};
        end else begin
            case (chr_idx)
                3'd2:    chr_bank = i_state.chr_banks[2];
                3'd3:    chr_bank = i_state.chr_banks[3];
                3'd4:    chr_bank = i_state.chr_banks[4];
                default: chr_bank = i_state.chr_banks[5];
            endcase
        end
    end

    // Target and address selection.
    always_comb begin
        o_rsp.target      = TGT_NONE;
        o_rsp.mapped_addr = '0;
        case (i_req.func)
            FUNC_CPU_WR, FUNC_CPU_RD: begin
                if (i_req.addr[15:13] == 3'b011) begin
                    o_rsp.target      = TGT_PRG_RAM;
                    o_rsp.mapped_addr = {8'b0, i_req.addr[12:0]};
                end else if (i_req.addr[15] && (i_req.func == FUNC_CPU_RD)) begin
                    o_rsp.target      = TGT_PRG_ROM;
                    o_rsp.mapped_addr = {prg_bank & i_state.prg_bank_mask, i_req.addr[12:0]};
                end
            end
            FUNC_PPU_RD: begin
                if (!i_req.addr[13]) begin
                    o_rsp.target      = TGT_CHR_ROM;
                    o_rsp.mapped_addr = {3'b0, chr_bank & i_state.chr_bank_mask,
                                         i_req.addr[9:0]};
                end else begin
                    o_rsp.target      = TGT_NT_RAM;
                    o_rsp.mapped_addr = {10'b0, i_state.mirror_pages[i_req.addr[11]],
                                         i_req.addr[9:0]};
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[design/cartridge_bank_mapper.sv]
// Top level of the cartridge bank mapper: input register, translator and result register.
// Depends on cbm_pkg, cbm_req_if, cbm_rsp_if, cbm_regs and cbm_xlate.
// Each accepted bus access word gives exactly one result word, passing through the input register
// and then the result register, and a new word is taken every cycle while the output is not
// stalled. The input register and the result register frame the single translation stage. Bank
// register writes carried by bus words take effect for the very next word. The user must load the
// size masks on the configuration port while no words are in flight; the block leaves this to the user.
`default_nettype none

module cartridge_bank_mapper
    import cbm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [7:0]         i_cfg_data,
    cbm_req_if.sink                 i_req,
    cbm_rsp_if.source               o_rsp
);

    logic        r_in_vld;
    t_req        r_in;
    logic        r_out_vld;
    t_rsp        r_out;
    logic        advance;
    logic        in_acc;
    t_req        req_word;
    t_rsp        xlate_rsp;
    t_bank_state bank_state;

    // Pipeline flow: the stage moves whenever the result register is free or being emptied.
    assign advance     = !r_out_vld || o_rsp.ready;
    assign i_req.ready = !r_in_vld || advance;
    assign in_acc      = i_req.valid && i_req.ready;

    assign req_word.func = i_req.func;
    assign req_word.addr = i_req.addr;
    assign req_word.data = i_req.data;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= req_word;
        end
    end

    // Bank registers, updated as the word leaves the input register.
    cbm_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_upd      (r_in_vld && advance),
        .i_req      (r_in),
        .o_state    (bank_state)
    );

    cbm_xlate u_xlate (
        .i_req   (r_in),
        .i_state (bank_state),
        .o_rsp   (xlate_rsp)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_out <= xlate_rsp;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.target      = r_out.target;
    assign o_rsp.mapped_addr = r_out.mapped_addr;

`ifndef SYNTHESIS
    // A word leaving the input register always lands in the result register.
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && advance |=> r_out_vld)
        else $error("word lost between input and result registers");

    // Unmapped accesses carry a zero address.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.target == TGT_NONE) |-> (o_rsp.mapped_addr == '0))
        else $error("unmapped access with non-zero address");

    // Nametable and program RAM addresses stay inside their windows.
    a_window_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && ((o_rsp.target == TGT_NT_RAM && o_rsp.mapped_addr[20:11] != '0) ||
                        (o_rsp.target == TGT_PRG_RAM && o_rsp.mapped_addr[20:13] != '0))
        |-> 1'b0)
        else $error("translated address outside its window");

    // Nothing accepted while both registers are full and the output is stalled.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && !o_rsp.ready |-> !i_req.ready)
        else $error("word accepted into a full pipeline");
`endif

endmodule

`default_nettype wire
